>>> hw/rtl/rbch_pkg.sv
// Shared types and constants for the ray/box nearest-hit block.
// No dependencies.
package rbch_pkg;

   localparam int BoxCount = 1024;
   localparam int CountW   = $clog2(BoxCount + 1);

   // Register indexes
   localparam logic [2:0] REG_ORG_X = 3'd0;
   localparam logic [2:0] REG_ORG_Y = 3'd1;
   localparam logic [2:0] REG_ORG_Z = 3'd2;
   localparam logic [2:0] REG_DIR_X = 3'd3;
   localparam logic [2:0] REG_DIR_Y = 3'd4;
   localparam logic [2:0] REG_DIR_Z = 3'd5;
   localparam logic [2:0] REG_MAXD  = 3'd6;
   localparam logic [2:0] REG_LAYER = 3'd7;

   // Numerator magnitude: |D| < 2^35, shifted by 13 -> 48 bits
   localparam int NumW = 48;
   localparam int DenW = 15;

   typedef struct packed {
      logic signed [31:0] box_center_x;
      logic signed [31:0] box_center_y;
      logic signed [31:0] box_center_z;
      logic [30:0]        box_size_x;
      logic [30:0]        box_size_y;
      logic [30:0]        box_size_z;
      logic               box_enabled;
      logic               box_is_square;
      logic [2:0]         box_layer;
      logic [9:0]         box_id;
      logic               last_box;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [9:0]  hit_id;
      logic [30:0] hit_distance;
   } rsp_type;

   // Divider control from sequencer
   typedef struct packed {
      logic            start;
      logic [NumW-1:0] num;
      logic [DenW:0]   den;
   } div_cmd_type;

endpackage

>>> hw/rtl/rbch_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Depends on rbch_pkg.
module rbch_divider import rbch_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  div_cmd_type     cmd,
   output logic            done,
   output logic [NumW-1:0] quot
);

   logic [NumW-1:0]      q_ff, q_in;
   logic [DenW+1:0]      r_ff, r_in;
   logic [DenW:0]        d_ff, d_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DenW+1:0]      trial;
   logic [DenW+1:0]      diff;

   // One shift-subtract step
   always_comb begin
      trial   = {r_ff[DenW:0], q_ff[NumW-1]};
      diff    = trial - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         q_in    = cmd.num;
         r_in    = '0;
         d_in    = cmd.den;
         cnt_in  = 6'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DenW+1]) begin
            r_in = diff;
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign done = busy_ff && (cnt_ff == 6'd1);
   assign quot = {q_ff[NumW-2:0], ~diff[DenW+1]};

endmodule

>>> hw/rtl/ray_box_closest_hit.sv
// Top level: ray/box slab test over a stream of boxes, nearest hit kept.
// Depends on rbch_pkg and rbch_divider.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | req_type box transaction
//  rsp_    | out       | rsp_valid/rsp_stall  | rsp_type result transaction
//  csr_    | in        | APB psel/penable     | 32-bit registers at 4*i
//
// A taking-part box costs up to six divisions in the shared divider, each a
// setup state and then 48 quotient bits, followed by evaluate and done; a skipped
// box goes straight to done, and no new box is taken before idle. An axis with a
// tiny direction takes only a setup state and no division.
// Reset is synchronous and clears control state and registers.
// A result waits in the output register while the next box is worked on; only
// a box that ends a query waits in done until that result has been delivered.
module ray_box_closest_hit import rbch_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_EVAL = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic signed [63:0] TPosInf = 64'sh4000_0000_0000_0000;
   localparam logic signed [63:0] TNegInf = -64'sh4000_0000_0000_0000;

   // Configuration registers
   logic signed [31:0] org_ff [3];
   logic signed [15:0] dir_ff [3];
   logic [30:0]        maxd_ff;
   logic [2:0]         qlayer_ff;
   logic               wr;
   logic [2:0]         widx;

   assign csr_pready = 1'b1;
   assign wr   = csr_psel && csr_penable && csr_pwrite;
   assign widx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            dir_ff[i] <= '0;
         end
         maxd_ff   <= '0;
         qlayer_ff <= '0;
      end else if (wr) begin
         unique case (widx)
            REG_ORG_X: org_ff[0] <= csr_pwdata;
            REG_ORG_Y: org_ff[1] <= csr_pwdata;
            REG_ORG_Z: org_ff[2] <= csr_pwdata;
            REG_DIR_X: dir_ff[0] <= csr_pwdata[15:0];
            REG_DIR_Y: dir_ff[1] <= csr_pwdata[15:0];
            REG_DIR_Z: dir_ff[2] <= csr_pwdata[15:0];
            REG_MAXD:  maxd_ff   <= csr_pwdata[30:0];
            REG_LAYER: qlayer_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (widx)
         REG_ORG_X: csr_prdata = org_ff[0];
         REG_ORG_Y: csr_prdata = org_ff[1];
         REG_ORG_Z: csr_prdata = org_ff[2];
         REG_DIR_X: csr_prdata = {{16{dir_ff[0][15]}}, dir_ff[0]};
         REG_DIR_Y: csr_prdata = {{16{dir_ff[1][15]}}, dir_ff[1]};
         REG_DIR_Z: csr_prdata = {{16{dir_ff[2][15]}}, dir_ff[2]};
         REG_MAXD:  csr_prdata = {1'b0, maxd_ff};
         REG_LAYER: csr_prdata = {29'd0, qlayer_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // Sequencer and query state
   logic [2:0]          state_ff, state_in;
   req_type             box_ff;
   logic [1:0]          axis_ff, axis_in;
   logic                side_ff, side_in;
   logic signed [63:0]  lo_ff, lo_in, hi_ff, hi_in, t1_ff, t1_in;
   logic                open_ff, open_in, found_ff, found_in;
   logic [31:0]         near_ff, near_in;
   logic [9:0]          nid_ff, nid_in;
   logic [CountW-1:0]   seen_ff, seen_in;
   logic                ov_ff, ov_in;
   rsp_type             out_ff, out_in;

   logic                accept;
   div_cmd_type         cmd;
   logic                ddone;
   logic [NumW-1:0]     quot;
   logic signed [15:0]  dcur;
   logic                axis_on;
   logic signed [34:0]  cen, dnum;
   logic [34:0]         dmag;
   logic signed [63:0]  tq, tn, tf, thit;
   logic                qneg_ff, qneg_in;
   logic                take;
   logic                zero_dir;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
   assign zero_dir  = (dir_ff[0] == 0) && (dir_ff[1] == 0) && (dir_ff[2] == 0);

   // Operands for the current axis and side
   always_comb begin
      logic signed [31:0] c;
      logic [30:0]        s;
      unique case (axis_ff)
         2'd0: begin c = box_ff.box_center_x; s = box_ff.box_size_x; end
         2'd1: begin c = box_ff.box_center_y; s = box_ff.box_size_y; end
         default: begin c = box_ff.box_center_z; s = box_ff.box_size_z; end
      endcase
      dcur    = dir_ff[axis_ff];
      axis_on = (dcur > 16'sd1) || (dcur < -16'sd1);
      cen     = 35'(c) * 35'sd2 - 35'(org_ff[axis_ff]) * 35'sd2;
      dnum    = side_ff ? cen + 35'($signed({1'b0, s})) : cen - 35'($signed({1'b0, s}));
      dmag    = dnum[34] ? 35'(-dnum) : 35'(dnum);
      cmd.num = {dmag[34:0], 13'd0};
      cmd.den = dcur[15] ? 16'(-dcur) : 16'(dcur);
      cmd.start = 1'b0;
      if (state_ff == ST_SETUP && axis_on) cmd.start = 1'b1;
   end

   rbch_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .done  (ddone),
      .quot  (quot)
   );

   assign tq   = qneg_ff ? -64'($signed({1'b0, quot})) : 64'($signed({1'b0, quot}));
   assign tn   = (t1_ff < tq) ? t1_ff : tq;
   assign tf   = (t1_ff < tq) ? tq : t1_ff;
   assign thit = lo_ff[63] ? 64'sd0 : lo_ff;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      side_in  = side_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      t1_in    = t1_ff;
      qneg_in  = qneg_ff;
      open_in  = open_ff;
      found_in = found_ff;
      near_in  = near_ff;
      nid_in   = nid_ff;
      seen_in  = seen_ff;
      ov_in    = ov_ff && rsp_stall;
      out_in   = out_ff;
      take     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!open_ff) begin
                  open_in  = 1'b1;
                  near_in  = {1'b0, maxd_ff};
                  nid_in   = '0;
                  found_in = 1'b0;
                  seen_in  = CountW'(1);
               end else begin
                  seen_in = seen_ff + CountW'(1);
               end
               axis_in = 2'd0;
               side_in = 1'b0;
               lo_in   = TNegInf;
               hi_in   = TPosInf;
               if (req_data.box_enabled && req_data.box_is_square && !zero_dir &&
                   (qlayer_ff == 3'd0 || req_data.box_layer == qlayer_ff))
                  state_in = ST_SETUP;
               else
                  state_in = ST_DONE;
            end
         end
         ST_SETUP: begin
            qneg_in = dnum[34] ^ dcur[15];
            if (axis_on) state_in = ST_WAIT;
            else if (axis_ff == 2'd2) state_in = ST_EVAL;
            else axis_in = axis_ff + 2'd1;
         end
         ST_WAIT: begin
            if (ddone) begin
               if (!side_ff) begin
                  t1_in   = tq;
                  side_in = 1'b1;
                  state_in = ST_SETUP;
               end else begin
                  if (tn > lo_ff) lo_in = tn;
                  if (tf < hi_ff) hi_in = tf;
                  side_in = 1'b0;
                  if (axis_ff == 2'd2) state_in = ST_EVAL;
                  else begin
                     axis_in  = axis_ff + 2'd1;
                     state_in = ST_SETUP;
                  end
               end
            end
         end
         ST_EVAL: begin
            if (!(hi_ff < 0 || lo_ff > hi_ff) && thit < $signed({32'd0, near_ff})) begin
               near_in  = thit[31:0];
               nid_in   = box_ff.box_id;
               found_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            take = box_ff.last_box || (seen_ff >= CountW'(BoxCount));
            if (take && ov_ff && rsp_stall) begin
               // previous result still held by the receiver
               state_in = ST_DONE;
            end else begin
               if (take) begin
                  out_in.hit          = found_ff;
                  out_in.hit_id       = found_ff ? nid_ff : 10'd0;
                  out_in.hit_distance = found_ff ? near_ff[30:0] : 31'd0;
                  ov_in   = 1'b1;
                  open_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) box_ff <= req_data;
      axis_ff <= axis_in;
      side_ff <= side_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      t1_ff   <= t1_in;
      qneg_ff <= qneg_in;
      near_ff <= near_in;
      nid_ff  <= nid_in;
      out_ff  <= out_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         open_ff  <= 1'b0;
         found_ff <= 1'b0;
         seen_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         found_ff <= found_in;
         seen_ff  <= seen_in;
         ov_ff    <= ov_in;
      end
   end

   // Checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !accept) else $error("box taken while busy");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(ov_ff) |-> $past(state_ff) == ST_DONE) else $error("result outside done");
   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ff.hit |-> out_ff.hit_id == 10'd0 && out_ff.hit_distance == 31'd0)
      else $error("miss carries data");

endmodule
